FILE: rtl/bcr_pkg.sv
`timescale 1ns / 1ps
// Box collision resolver package: shared types, codes and overlap helpers.
// Used by bcr_cell and box_collision_resolver; depends on nothing.
package bcr_pkg;

  localparam int COORD_W = 16;
  localparam int SIZE_W  = 12;
  localparam int COUNT_W = 5;
  localparam int INDEX_W = 4;
  localparam int MASK_W  = 16;
  localparam int REG_W   = 3;
  localparam int WIDE_W  = 20;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [SIZE_W-1:0]  size_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_SET   = 2'd1,
    CMD_MOVE  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [REG_W-1:0] {
    REG_OFFSET_X = 3'd0,
    REG_OFFSET_Y = 3'd1,
    REG_WIDTH    = 3'd2,
    REG_HEIGHT   = 3'd3,
    REG_COUNT    = 3'd4
  } reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_REPLY
  } state_t;

  // Own hitbox geometry and table size, held in the top level.
  typedef struct packed {
    coord_t             offset_x;
    coord_t             offset_y;
    size_t              width;
    size_t              height;
    logic [COUNT_W-1:0] count;
  } cfg_t;

  // Table entry write, broadcast to every cell.
  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] index;
    coord_t             x;
    coord_t             y;
    size_t              w;
    size_t              h;
    logic               blocks;
  } wr_t;

  // Record handed from cell to cell.
  typedef struct packed {
    logic               query;
    coord_t             tx;
    coord_t             ty;
    coord_t             old_y;
    logic               hit;
    coord_t             nx;
    coord_t             ny;
    logic [INDEX_W-1:0] stopper;
    logic [MASK_W-1:0]  mask;
  } rec_t;

  function automatic coord_t sat16(wide_t v);
    if (v > wide_t'(20'sd32767)) begin
      return coord_t'(16'sh7fff);
    end else if (v < -wide_t'(20'sd32768)) begin
      return coord_t'(16'sh8000);
    end
    return coord_t'(v[COORD_W-1:0]);
  endfunction

  function automatic logic strict_span(wide_t lo, wide_t size, wide_t elo, wide_t esize);
    return (lo + size > elo) && (lo < elo + esize);
  endfunction

  function automatic logic loose_span(wide_t lo, wide_t size, wide_t elo, wide_t esize);
    return (lo + size >= elo) && (lo <= elo + esize);
  endfunction

endpackage

FILE: rtl/bcr_cell.sv
`timescale 1ns / 1ps
// One cell of the collider chain: holds one table entry and resolves the
// passing record against it. Depends on bcr_pkg.
module bcr_cell import bcr_pkg::*; #(
  parameter int CELL_INDEX = 0
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  wr_t  wr,
  input  logic vld_in,
  input  rec_t rec_in,
  output logic vld_out,
  output rec_t rec_out
);

  localparam logic                HAS_BIT   = CELL_INDEX < MASK_W;
  localparam int                  MASK_POS  = (CELL_INDEX < MASK_W) ? CELL_INDEX : 0;
  localparam logic [INDEX_W-1:0]  STOP_CODE = INDEX_W'(CELL_INDEX % (1 << INDEX_W));

  coord_t entry_x;
  coord_t entry_y;
  size_t  entry_w;
  size_t  entry_h;
  logic   entry_blk;

  rec_t   rec_next;
  logic   live;
  wide_t  ex, ey, ew, eh, bw, bh, ox, oy;
  wide_t  hx_t, hy_old, hx_push, hy_t;
  logic   x_hit, y_hit;
  coord_t nx, ny;

  always_ff @(posedge clk) begin
    if (wr.en && (int'(wr.index) == CELL_INDEX)) begin
      entry_x   <= wr.x;
      entry_y   <= wr.y;
      entry_w   <= wr.w;
      entry_h   <= wr.h;
      entry_blk <= wr.blocks;
    end
  end

  always_comb begin
    ex = wide_t'(entry_x);
    ey = wide_t'(entry_y);
    ew = wide_t'(entry_w);
    eh = wide_t'(entry_h);
    bw = wide_t'(cfg.width);
    bh = wide_t'(cfg.height);
    ox = wide_t'(cfg.offset_x);
    oy = wide_t'(cfg.offset_y);

    hx_t   = wide_t'(rec_in.tx) + ox;
    hy_old = wide_t'(rec_in.old_y) + oy;
    hy_t   = wide_t'(rec_in.ty) + oy;

    // x first, against the old y
    x_hit = entry_blk && strict_span(hx_t, bw, ex, ew) && strict_span(hy_old, bh, ey, eh);
    if (!x_hit) begin
      nx = rec_in.tx;
    end else if (hx_t < ex) begin
      nx = sat16(ex - bw - ox);
    end else begin
      nx = sat16(ex + ew - ox);
    end

    // then y, against the x just resolved
    hx_push = wide_t'(nx) + ox;
    y_hit = entry_blk && strict_span(hx_push, bw, ex, ew) && strict_span(hy_t, bh, ey, eh);
    if (!y_hit) begin
      ny = rec_in.ty;
    end else if (hy_t < ey) begin
      ny = sat16(ey - bh - oy);
    end else begin
      ny = sat16(ey + eh - oy);
    end

    live = vld_in && (int'(cfg.count) > CELL_INDEX) && !rec_in.hit;

    rec_next = rec_in;
    if (live) begin
      if (rec_in.query) begin
        if (HAS_BIT && loose_span(hx_t, bw, ex, ew) && loose_span(hy_t, bh, ey, eh)) begin
          rec_next.mask[MASK_POS] = 1'b1;
        end
      end else if (x_hit || y_hit) begin
        // first hit wins; later cells pass the record on untouched
        rec_next.hit     = 1'b1;
        rec_next.nx      = nx;
        rec_next.ny      = ny;
        rec_next.stopper = STOP_CODE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    rec_out <= rec_next;
  end

endmodule

FILE: rtl/box_collision_resolver.sv
`timescale 1ns / 1ps
// Box collision resolver top level: command port, configuration registers,
// own position and the chain of collider cells. Depends on bcr_pkg, bcr_cell.
//
//  channel   handshake              payload
//  command   start, busy            cmd, entry_index, coord_x/y, entry_width/height,
//                                   entry_blocks
//  result    done (one cycle)       cur_x, cur_y, was_blocked, blocking_entry,
//                                   overlap_mask
//  config    cfg_valid, cfg_ready   cfg_index, cfg_data
//
// A table write answers with done in the cycle after it is taken.
// A move or query is launched into the cell chain, walks it one cell per
// cycle and answers after its record leaves the last cell; busy holds off
// new commands meanwhile, so moves and queries run one at a time. A new
// command may be taken in the cycle done is high.
// Reset clears the own position and the configuration; the table holds
// nothing useful until written. The receiver cannot stall a result.
module box_collision_resolver import bcr_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  input  logic [1:0]          cmd,
  input  logic [INDEX_W-1:0]  entry_index,
  input  logic signed [15:0]  coord_x,
  input  logic signed [15:0]  coord_y,
  input  logic [SIZE_W-1:0]   entry_width,
  input  logic [SIZE_W-1:0]   entry_height,
  input  logic                entry_blocks,
  output logic signed [15:0]  cur_x,
  output logic signed [15:0]  cur_y,
  output logic                was_blocked,
  output logic [INDEX_W-1:0]  blocking_entry,
  output logic [MASK_W-1:0]   overlap_mask,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [REG_W-1:0]    cfg_index,
  input  logic [15:0]         cfg_data
);

  state_t state, state_next;
  cfg_t   cfg;
  coord_t own_x, own_y;
  logic   accept;
  wr_t    wr;

  logic   launch_vld;
  rec_t   launch;
  coord_t tx_next, ty_next;

  logic   chain_vld [TABLE_DEPTH+1];
  rec_t   chain_rec [TABLE_DEPTH+1];
  logic   tail_vld;
  rec_t   tail;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OFFSET_X: cfg.offset_x <= coord_t'(cfg_data);
        REG_OFFSET_Y: cfg.offset_y <= coord_t'(cfg_data);
        REG_WIDTH:    cfg.width    <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT:   cfg.height   <= cfg_data[SIZE_W-1:0];
        REG_COUNT:    cfg.count    <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    wr.en     = accept && (cmd == CMD_WRITE);
    wr.index  = entry_index;
    wr.x      = coord_x;
    wr.y      = coord_y;
    wr.w      = entry_width;
    wr.h      = entry_height;
    wr.blocks = entry_blocks;
  end

  // move target, saturated for a delta
  always_comb begin
    unique case (cmd)
      CMD_SET: begin
        tx_next = coord_x;
        ty_next = coord_y;
      end
      CMD_MOVE: begin
        tx_next = sat16(wide_t'(own_x) + wide_t'(coord_x));
        ty_next = sat16(wide_t'(own_y) + wide_t'(coord_y));
      end
      default: begin
        tx_next = own_x;
        ty_next = own_y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      launch_vld <= 1'b0;
    end else begin
      launch_vld <= accept && (cmd != CMD_WRITE);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      launch.query   <= (cmd == CMD_QUERY);
      launch.tx      <= tx_next;
      launch.ty      <= ty_next;
      launch.old_y   <= own_y;
      launch.hit     <= 1'b0;
      launch.nx      <= tx_next;
      launch.ny      <= ty_next;
      launch.stopper <= '0;
      launch.mask    <= '0;
    end
  end

  assign chain_vld[0] = launch_vld;
  assign chain_rec[0] = launch;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    bcr_cell #(
      .CELL_INDEX(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cfg     (cfg),
      .wr      (wr),
      .vld_in  (chain_vld[i]),
      .rec_in  (chain_rec[i]),
      .vld_out (chain_vld[i+1]),
      .rec_out (chain_rec[i+1])
    );
  end

  assign tail_vld = chain_vld[TABLE_DEPTH];
  assign tail     = chain_rec[TABLE_DEPTH];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE, ST_REPLY: begin
        if (accept) begin
          state_next = (cmd == CMD_WRITE) ? ST_REPLY : ST_SCAN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (tail_vld) begin
          state_next = ST_REPLY;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    busy = (state == ST_SCAN);
    done = (state == ST_REPLY);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      own_x <= '0;
      own_y <= '0;
    end else begin
      state <= state_next;
      if (tail_vld && !tail.query) begin
        own_x <= tail.nx;
        own_y <= tail.ny;
      end
    end
  end

  // result beat, held for the reply cycle
  always_ff @(posedge clk) begin
    if (accept && (cmd == CMD_WRITE)) begin
      cur_x          <= own_x;
      cur_y          <= own_y;
      was_blocked    <= 1'b0;
      blocking_entry <= '0;
      overlap_mask   <= '0;
    end else if (tail_vld) begin
      if (tail.query) begin
        cur_x          <= own_x;
        cur_y          <= own_y;
        was_blocked    <= (tail.mask != '0);
        blocking_entry <= '0;
        overlap_mask   <= tail.mask;
      end else begin
        cur_x          <= tail.nx;
        cur_y          <= tail.ny;
        was_blocked    <= tail.hit;
        blocking_entry <= tail.stopper;
        overlap_mask   <= '0;
      end
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    !(done && busy))
    else $error("result beat while scan in progress");

  a_write_reply: assert property (@(posedge clk) disable iff (rst)
    (accept && (cmd == CMD_WRITE)) |=> (done && !was_blocked && (overlap_mask == '0)))
    else $error("table write not answered in the next cycle");

  a_stopper_blocked: assert property (@(posedge clk) disable iff (rst)
    (done && (blocking_entry != '0)) |-> (was_blocked && (overlap_mask == '0)))
    else $error("stopping entry reported without a block");

  a_mask_blocked: assert property (@(posedge clk) disable iff (rst)
    (done && (overlap_mask != '0)) |-> was_blocked)
    else $error("overlap mask without overlap flag");

  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (tail_vld) |-> (state == ST_SCAN))
    else $error("chain output outside of a scan");

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for box_collision_resolver: drives table writes, moves
// and queries, predicts each result and checks it field by field. Uses bcr_pkg.
module testbench;
  import bcr_pkg::*;

  localparam int DEPTH     = 16;
  localparam int PHASES    = 10;
  localparam int PER_PHASE = 115;

  typedef struct {
    int x;
    int y;
    int w;
    int h;
    bit blocks;
  } collider_t;

  typedef struct {
    coord_t             x;
    coord_t             y;
    logic               blocked;
    logic [INDEX_W-1:0] stopper;
    logic [MASK_W-1:0]  mask;
  } answer_t;

  typedef struct {
    cmd_t               op;
    logic [INDEX_W-1:0] idx;
    coord_t             x;
    coord_t             y;
    size_t              w;
    size_t              h;
    logic               blocks;
  } command_t;

  // Tracks own position, hitbox registers and the collider table; holds the
  // answers still owed by the block.
  class collision_tracker;
    int off_x, off_y, box_w, box_h, count;
    int own_x, own_y;
    collider_t colliders[DEPTH];
    answer_t owed_answers[$];
    int errors, commands, pushed_moves, hit_queries;

    function int clamp16(int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function bit strict_overlap(int px, int py, collider_t e);
      int hx, hy;
      hx = px + off_x;
      hy = py + off_y;
      return hx + box_w > e.x && hx < e.x + e.w && hy + box_h > e.y && hy < e.y + e.h;
    endfunction

    function bit loose_overlap(collider_t e);
      int hx, hy;
      hx = own_x + off_x;
      hy = own_y + off_y;
      return hx + box_w >= e.x && hx <= e.x + e.w && hy + box_h >= e.y && hy <= e.y + e.h;
    endfunction

    function void set_reg(reg_t r, logic [15:0] data);
      case (r)
        REG_OFFSET_X: off_x = int'($signed(data));
        REG_OFFSET_Y: off_y = int'($signed(data));
        REG_WIDTH:    box_w = int'(data[SIZE_W-1:0]);
        REG_HEIGHT:   box_h = int'(data[SIZE_W-1:0]);
        REG_COUNT:    count = int'(data[COUNT_W-1:0]);
        default: ;
      endcase
    endfunction

    function void note_command(command_t c);
      answer_t a;
      int n, tx, ty, old_y, nx, ny;
      bit hit;
      a = '{default: '0};
      n = (count > DEPTH) ? DEPTH : count;
      commands++;
      case (c.op)
        CMD_WRITE: begin
          colliders[c.idx] = '{int'(c.x), int'(c.y), int'(c.w), int'(c.h), c.blocks};
        end
        CMD_QUERY: begin
          for (int i = 0; i < n; i++)
            if (loose_overlap(colliders[i])) a.mask[i] = 1'b1;
          a.blocked = (a.mask != '0);
          if (a.blocked) hit_queries++;
        end
        default: begin
          tx = (c.op == CMD_SET) ? int'(c.x) : clamp16(own_x + int'(c.x));
          ty = (c.op == CMD_SET) ? int'(c.y) : clamp16(own_y + int'(c.y));
          old_y = own_y;
          nx = tx;
          ny = ty;
          hit = 1'b0;
          // x first against the old y, then y against the settled x
          for (int i = 0; i < n; i++) begin
            nx = tx;
            ny = old_y;
            if (colliders[i].blocks && strict_overlap(nx, ny, colliders[i])) begin
              if (nx + off_x < colliders[i].x)
                nx = clamp16(colliders[i].x - box_w - off_x);
              else
                nx = clamp16(colliders[i].x + colliders[i].w - off_x);
              hit = 1'b1;
            end
            ny = ty;
            if (colliders[i].blocks && strict_overlap(nx, ny, colliders[i])) begin
              if (ny + off_y < colliders[i].y)
                ny = clamp16(colliders[i].y - box_h - off_y);
              else
                ny = clamp16(colliders[i].y + colliders[i].h - off_y);
              hit = 1'b1;
            end
            if (hit) begin
              a.stopper = INDEX_W'(i);
              break;
            end
          end
          own_x = nx;
          own_y = ny;
          a.blocked = hit;
          if (hit) pushed_moves++;
        end
      endcase
      a.x = coord_t'(own_x);
      a.y = coord_t'(own_y);
      owed_answers = {owed_answers, a};
    endfunction

    function void flag(string what);
      errors++;
      $error("%s", what);
    endfunction

    function void compare(string field, logic signed [31:0] want, logic signed [31:0] got);
      if (want === got) return;
      errors++;
      $error("%s: expected %0d, got %0d", field, want, got);
    endfunction

    function void check_result(answer_t got);
      answer_t want;
      if (owed_answers.size() == 0) begin
        flag("result beat with no command outstanding");
        return;
      end
      want = owed_answers.pop_front();
      compare("cur_x", want.x, got.x);
      compare("cur_y", want.y, got.y);
      compare("was_blocked", {31'd0, want.blocked}, {31'd0, got.blocked});
      compare("blocking_entry", 32'(want.stopper), 32'(got.stopper));
      compare("overlap_mask", 32'(want.mask), 32'(got.mask));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy, done;
  logic [1:0] cmd = '0;
  logic [INDEX_W-1:0] entry_index = '0;
  logic signed [15:0] coord_x = '0;
  logic signed [15:0] coord_y = '0;
  logic [SIZE_W-1:0] entry_width = '0;
  logic [SIZE_W-1:0] entry_height = '0;
  logic entry_blocks = 1'b0;
  logic signed [15:0] cur_x, cur_y;
  logic was_blocked;
  logic [INDEX_W-1:0] blocking_entry;
  logic [MASK_W-1:0] overlap_mask;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [REG_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  collision_tracker sb = new();
  answer_t seen;
  command_t taken;
  int settings_used = 0;
  int idle_mode = 1;

  box_collision_resolver #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .cmd(cmd), .entry_index(entry_index), .coord_x(coord_x), .coord_y(coord_y),
    .entry_width(entry_width), .entry_height(entry_height), .entry_blocks(entry_blocks),
    .cur_x(cur_x), .cur_y(cur_y), .was_blocked(was_blocked),
    .blocking_entry(blocking_entry), .overlap_mask(overlap_mask),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Sample every handshake on the edge that completes it.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        seen.x = cur_x;
        seen.y = cur_y;
        seen.blocked = was_blocked;
        seen.stopper = blocking_entry;
        seen.mask = overlap_mask;
        sb.check_result(seen);
      end
      if (start && !busy) begin
        taken.op = cmd_t'(cmd);
        taken.idx = entry_index;
        taken.x = coord_x;
        taken.y = coord_y;
        taken.w = entry_width;
        taken.h = entry_height;
        taken.blocks = entry_blocks;
        sb.note_command(taken);
      end
      if (cfg_valid && cfg_ready) sb.set_reg(reg_t'(cfg_index), cfg_data);
    end
  end

  function automatic command_t mk(cmd_t op, int idx, int x, int y, int w, int h, bit b);
    command_t c;
    c.op = op;
    c.idx = INDEX_W'(idx);
    c.x = coord_t'(x);
    c.y = coord_t'(y);
    c.w = SIZE_W'(w);
    c.h = SIZE_W'(h);
    c.blocks = b;
    return c;
  endfunction

  // Mostly commands around a small arena so boxes meet; a few full-range ones.
  function automatic command_t random_command();
    command_t c;
    int pick;
    pick = $urandom_range(0, 99);
    c = mk(CMD_WRITE, $urandom_range(0, 15),
           int'($urandom_range(0, 600)) - 300, int'($urandom_range(0, 600)) - 300,
           $urandom_range(2, 120), $urandom_range(2, 120), $urandom_range(0, 3) != 0);
    if (pick >= 12 && pick < 47) begin
      c.op = CMD_SET;
    end else if (pick >= 47 && pick < 82) begin
      c.op = CMD_MOVE;
      c.x = coord_t'(int'($urandom_range(0, 128)) - 64);
      c.y = coord_t'(int'($urandom_range(0, 128)) - 64);
    end else if (pick >= 82 && pick < 94) begin
      c.op = CMD_QUERY;
    end else if (pick >= 94) begin
      c = mk(cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom);
    end
    return c;
  endfunction

  function automatic int gap_len();
    int r;
    if (idle_mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold start until the beat is taken; returns on the accepting edge.
  task automatic issue(command_t c);
    start <= 1'b1;
    cmd <= c.op;
    entry_index <= c.idx;
    coord_x <= c.x;
    coord_y <= c.y;
    entry_width <= c.w;
    entry_height <= c.h;
    entry_blocks <= c.blocks;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (sb.owed_answers.size() != 0);
  endtask

  task automatic send(command_t c);
    issue(c);
    pause(gap_len());
  endtask

  // Idle the block, then write all five registers back to back.
  task automatic configure(int ox, int oy, int w, int h, int n);
    logic [15:0] vals[5];
    drain();
    vals[REG_OFFSET_X] = 16'(ox);
    vals[REG_OFFSET_Y] = 16'(oy);
    vals[REG_WIDTH]    = {4'($urandom), 12'(w)};
    vals[REG_HEIGHT]   = {4'($urandom), 12'(h)};
    vals[REG_COUNT]    = {11'($urandom), 5'(n)};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_W'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table: moves land on target, deltas saturate.
    send(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_SET, 0, 32767, -32768, 0, 0, 0));
    send(mk(CMD_MOVE, 0, 32767, -32768, 0, 0, 0));
    send(mk(CMD_MOVE, 0, -32768, 32767, 0, 0, 0));
    for (int i = 0; i < DEPTH; i++) begin
      case (i)
        0:  send(mk(CMD_WRITE, i, -32768, -32768, 4095, 4095, 1));
        1:  send(mk(CMD_WRITE, i, 0, 0, 0, 0, 1));
        14: send(mk(CMD_WRITE, i, 100, -50, 0, 4095, 1));
        15: send(mk(CMD_WRITE, i, 32767, 32767, 4095, 4095, 1));
        default: send(mk(CMD_WRITE, i, (i - 2) * 64 - 400, ((i % 3) - 1) * 80, 40, 30,
                         (i % 4) != 3));
      endcase
    end
    // Count above the table depth; push out at both corners of the plane.
    configure(-4, -4, 16, 16, 17);
    send(mk(CMD_SET, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0));
    send(mk(CMD_SET, 0, -32768, -32768, 0, 0, 0));
    send(mk(CMD_SET, 0, 32767, 32767, 0, 0, 0));
    send(mk(CMD_MOVE, 0, -100, 40, 0, 0, 0));
    send(mk(CMD_QUERY, 0, 0, 0, 0, 0, 0));

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(32767, -32768, 4095, 4095, 16);
        1: configure(-32768, 32767, 0, 0, 31);
        default: configure(int'($urandom_range(0, 40)) - 20, int'($urandom_range(0, 40)) - 20,
                           $urandom_range(4, 64), $urandom_range(4, 64),
                           $urandom_range(0, 20));
      endcase
      idle_mode = (p % 3 == 2) ? 0 : 1;
      for (int k = 0; k < PER_PHASE; k++) begin
        issue(random_command());
        if (k == PER_PHASE / 2 || $urandom_range(0, 199) == 0)
          drain();
        else
          pause(gap_len());
      end
    end

    drain();
    repeat (DEPTH + 8) @(posedge clk);
    if (sb.owed_answers.size() != 0) sb.flag("results still owed at end of run");
    $display("Ran %0d commands over %0d register settings: %0d moves pushed out,",
             sb.commands, settings_used, sb.pushed_moves);
    $display("%0d queries found overlap, %0d mismatches.", sb.hit_queries, sb.errors);
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Run timed out.");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
